[sv/lfl_pkg.sv]
package lfl_pkg;

   localparam int SIZE_W     = 15;
   localparam int FLEX_W     = 7;
   localparam int FLEX_IN_W  = 8;
   localparam int RECT_W     = 16;
   localparam int POS_W      = 17;
   localparam int SUM_W      = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DEFAULT_MAX_CHILDREN = 16;
   localparam int FLEX_MAX   = 127;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_AXIS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_W = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_H = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ALIGN  = 3'd6;

   // Cross-axis alignment codes.
   localparam logic [1:0] ALIGN_START   = 2'd0;
   localparam logic [1:0] ALIGN_CENTER  = 2'd1;
   localparam logic [1:0] ALIGN_END     = 2'd2;
   localparam logic [1:0] ALIGN_STRETCH = 2'd3;

   typedef struct packed {
      logic [SIZE_W-1:0] main_size;
      logic [SIZE_W-1:0] cross_size;
      logic [FLEX_W-1:0] flex;
   } child_type;

   // Saturating add into the 20-bit sum range.
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {{(SUM_W+1-SIZE_W){1'b0}}, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

endpackage

[sv/lfl_if.sv]
interface lfl_req_if
   import lfl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [SIZE_W-1:0]    desired_width;
   logic [SIZE_W-1:0]    desired_height;
   logic signed [FLEX_IN_W-1:0] flex_weight;
   logic                 last_child;

   modport source (output valid, desired_width, desired_height, flex_weight, last_child,
                   input ready);
   modport sink   (input valid, desired_width, desired_height, flex_weight, last_child,
                   output ready);
endinterface

interface lfl_rsp_if
   import lfl_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [SIZE_W-1:0]       main_size;
   logic signed [POS_W-1:0] cross_pos;
   logic [SIZE_W-1:0]       cross_size;
   logic [SUM_W-1:0]        content_size;
   logic                    overflowed;
   logic                    last_result;

   modport source (output valid, main_size, cross_pos, cross_size, content_size,
                   overflowed, last_result, input ready);
   modport sink   (input valid, main_size, cross_pos, cross_size, content_size,
                   overflowed, last_result, output ready);
endinterface

[sv/linear_flex_layout.sv]
// Channel   Direction  Carries
// req_chan  in         one child: desired width, height, flex weight, last mark
// rsp_chan  out        one laid-out child: main size, cross position and size,
//                      content size, overflow flag, last mark
// csr_*     in         register writes, no read-back
//
// A child that is not the last is stored as it is taken. After the last child,
// each result is placed and, for a flexing child, sized by the bit-serial
// divider, which runs 15 steps; an output stall holds each result until taken.
// Synchronous active-high reset clears control state; the child store is
// undefined until written. No child is taken while results are pending.
module linear_flex_layout
   import lfl_pkg::*;
#(
   parameter int MAX_CHILDREN = DEFAULT_MAX_CHILDREN
) (
   input  logic                  clock,
   input  logic                  reset,
   lfl_req_if.sink               req_chan,
   lfl_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
   localparam int IDX_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
   localparam int FT_W  = $clog2(MAX_CHILDREN * FLEX_MAX + 1);
   localparam int PW    = SIZE_W + FT_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_CALC  = 3'd3;
   localparam logic [2:0] S_START = 3'd4;
   localparam logic [2:0] S_WAIT  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   // Configuration registers.
   logic                     axis_ff;
   logic [SIZE_W-1:0]        gap_ff;
   logic signed [RECT_W-1:0] rect_x_ff, rect_y_ff, rect_w_ff, rect_h_ff;
   logic [1:0]               align_ff;

   // Container state.
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in, idx_ff, idx_in;
   logic [SUM_W-1:0]  fixed_sum_ff, fixed_sum_in, content_ff, content_in;
   logic [FT_W-1:0]   flex_total_ff, flex_total_in, used_flex_ff, used_flex_in;
   logic [SIZE_W-1:0] flex_space_ff, flex_space_in, used_space_ff, used_space_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic              dropped_ff, dropped_in;

   // Result register.
   logic [SIZE_W-1:0] o_main_ff, o_main_in, o_csz_ff, o_csz_in;
   logic [POS_W-1:0]  o_cpos_ff, o_cpos_in;
   logic              o_last_ff, o_last_in;

   logic              req_fire, rsp_fire;
   logic [FLEX_W-1:0] in_flex;
   child_type         wr_child, rd_child;
   logic              wr_en;
   logic              div_start, div_done;
   logic [SIZE_W-1:0] div_q;

   logic signed [RECT_W-1:0] rmain, rcross, rpos;
   logic [SIZE_W-1:0]        avail, spare, csz_c;
   logic [POS_W:0]           cpos_c, rpos_ext, rcross_ext;
   logic [SUM_W+1:0]         free_sp;
   logic [SUM_W-1:0]         sum_gap;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = (state_ff == S_OUT);

   assign rsp_chan.main_size    = o_main_ff;
   assign rsp_chan.cross_pos    = o_cpos_ff;
   assign rsp_chan.cross_size   = o_csz_ff;
   assign rsp_chan.content_size = content_ff;
   assign rsp_chan.overflowed   = dropped_ff;
   assign rsp_chan.last_result  = o_last_ff;

   assign in_flex = req_chan.flex_weight[FLEX_IN_W-1] ? '0 : req_chan.flex_weight[FLEX_W-1:0];
   assign wr_child.main_size  = axis_ff ? req_chan.desired_height : req_chan.desired_width;
   assign wr_child.cross_size = axis_ff ? req_chan.desired_width : req_chan.desired_height;
   assign wr_child.flex       = in_flex;
   assign wr_en = req_fire && (count_ff < CNT_W'(MAX_CHILDREN));

   assign rmain  = axis_ff ? rect_h_ff : rect_w_ff;
   assign rcross = axis_ff ? rect_w_ff : rect_h_ff;
   assign rpos   = axis_ff ? rect_x_ff : rect_y_ff;
   assign avail  = rcross[RECT_W-1] ? '0 : rcross[SIZE_W-1:0];
   assign div_start = (state_ff == S_START);

   lfl_store #(
      .DEPTH (MAX_CHILDREN),
      .IDX_W (IDX_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[IDX_W-1:0]),
      .wr_data    (wr_child),
      .rd_addr    (idx_ff[IDX_W-1:0]),
      .rd_data_ff (rd_child)
   );

   lfl_div #(
      .QW (SIZE_W),
      .DW (FT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (flex_total_ff),
      .done_ff  (div_done),
      .quo_ff   (div_q)
   );

   // Cross-axis placement of the child being read out.
   always_comb begin
      rpos_ext   = {{(POS_W+1-RECT_W){rpos[RECT_W-1]}}, rpos};
      rcross_ext = {{(POS_W+1-RECT_W){rcross[RECT_W-1]}}, rcross};
      spare  = avail - rd_child.cross_size;
      csz_c  = rd_child.cross_size;
      cpos_c = rpos_ext;
      unique case (align_ff)
         ALIGN_START: begin
         end
         ALIGN_CENTER: begin
            if (avail > rd_child.cross_size) begin
               cpos_c = rpos_ext + {{(POS_W+2-SIZE_W){1'b0}}, spare[SIZE_W-1:1]};
            end
         end
         ALIGN_END: begin
            cpos_c = rpos_ext + rcross_ext
                   - {{(POS_W+1-SIZE_W){1'b0}}, rd_child.cross_size};
         end
         ALIGN_STRETCH: begin
            csz_c = avail;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      fixed_sum_in  = fixed_sum_ff;
      content_in    = content_ff;
      flex_total_in = flex_total_ff;
      used_flex_in  = used_flex_ff;
      flex_space_in = flex_space_ff;
      used_space_in = used_space_ff;
      prod_in       = prod_ff;
      dropped_in    = dropped_ff;
      o_main_in     = o_main_ff;
      o_cpos_in     = o_cpos_ff;
      o_csz_in      = o_csz_ff;
      o_last_in     = o_last_ff;
      sum_gap       = (count_ff != '0) ? sat_add(fixed_sum_ff, gap_ff) : fixed_sum_ff;
      free_sp       = {{(SUM_W+2-RECT_W){rmain[RECT_W-1]}}, rmain} - {2'b00, fixed_sum_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (wr_en) begin
                  fixed_sum_in  = (in_flex == '0) ? sat_add(sum_gap, wr_child.main_size)
                                                  : sum_gap;
                  flex_total_in = flex_total_ff + FT_W'(in_flex);
                  count_in      = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_chan.last_child) begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            // Free space is only shared when some child flexes.
            flex_space_in = '0;
            content_in    = fixed_sum_ff;
            if (flex_total_ff != '0) begin
               if (!free_sp[SUM_W+1] && (free_sp != '0)) begin
                  flex_space_in = free_sp[SIZE_W-1:0];
               end
               content_in = sat_add(fixed_sum_ff, flex_space_in);
            end
            idx_in        = '0;
            used_flex_in  = '0;
            used_space_in = '0;
            prod_in       = '0;
            state_in      = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            o_csz_in  = csz_c;
            o_last_in = (idx_ff == count_ff - CNT_W'(1));
            if (cpos_c[POS_W] && !cpos_c[POS_W-1]) begin
               o_cpos_in = {1'b1, {(POS_W-1){1'b0}}};
            end else if (!cpos_c[POS_W] && cpos_c[POS_W-1]) begin
               o_cpos_in = {1'b0, {(POS_W-1){1'b1}}};
            end else begin
               o_cpos_in = cpos_c[POS_W-1:0];
            end
            if ((flex_total_ff != '0) && (rd_child.flex != '0)) begin
               used_flex_in = used_flex_ff + FT_W'(rd_child.flex);
               prod_in      = prod_ff + PW'(flex_space_ff) * PW'(rd_child.flex);
               state_in     = S_START;
            end else begin
               o_main_in = rd_child.main_size;
               state_in  = S_OUT;
            end
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               o_main_in     = div_q - used_space_ff;
               used_space_in = div_q;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               if (o_last_ff) begin
                  count_in      = '0;
                  fixed_sum_in  = '0;
                  flex_total_in = '0;
                  flex_space_in = '0;
                  used_flex_in  = '0;
                  used_space_in = '0;
                  dropped_in    = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      content_ff <= content_in;
      prod_ff    <= prod_in;
      o_main_ff  <= o_main_in;
      o_cpos_ff  <= o_cpos_in;
      o_csz_ff   <= o_csz_in;
      o_last_ff  <= o_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         fixed_sum_ff  <= '0;
         flex_total_ff <= '0;
         used_flex_ff  <= '0;
         flex_space_ff <= '0;
         used_space_ff <= '0;
         dropped_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         fixed_sum_ff  <= fixed_sum_in;
         flex_total_ff <= flex_total_in;
         used_flex_ff  <= used_flex_in;
         flex_space_ff <= flex_space_in;
         used_space_ff <= used_space_in;
         dropped_ff    <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff   <= 1'b0;
         gap_ff    <= '0;
         rect_x_ff <= '0;
         rect_y_ff <= '0;
         rect_w_ff <= '0;
         rect_h_ff <= '0;
         align_ff  <= ALIGN_START;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_AXIS:   axis_ff   <= csr_wdata[0];
            REG_GAP:    gap_ff    <= csr_wdata[SIZE_W-1:0];
            REG_RECT_X: rect_x_ff <= csr_wdata;
            REG_RECT_Y: rect_y_ff <= csr_wdata;
            REG_RECT_W: rect_w_ff <= csr_wdata;
            REG_RECT_H: rect_h_ff <= csr_wdata;
            REG_ALIGN:  align_ff  <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

[sv/lfl_store.sv]
module lfl_store
   import lfl_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_CHILDREN,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  child_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output child_type        rd_data_ff
);

   child_type mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

[sv/lfl_div.sv]
module lfl_div
   import lfl_pkg::*;
#(
   parameter int QW = SIZE_W,
   parameter int DW = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [QW+DW-1:0] dividend,
   input  logic [DW-1:0]    divisor,
   output logic             done_ff,
   output logic [QW-1:0]    quo_ff
);

   localparam int STEP_W = $clog2(QW + 1);

   // The upper DW bits of the dividend must already be below the divisor,
   // so the quotient fits in QW bits and QW restoring steps suffice.
   logic [DW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, done_in;
   logic [DW:0]       trial, diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[QW-1]};
      diff    = trial - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[QW+DW-1:QW];
         quo_in  = dividend[QW-1:0];
         step_in = STEP_W'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
         end else begin
            rem_in = trial[DW-1:0];
         end
         quo_in  = {quo_ff[QW-2:0], ~diff[DW]};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

[verif/tb_linear_flex_layout.sv]
module tb_linear_flex_layout;
   timeunit 1ns;
   timeprecision 1ps;

   import lfl_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam logic AXIS_ROW    = 1'b0;
   localparam logic AXIS_COLUMN = 1'b1;
   localparam int SETTLE_CYCLES = 30;
   localparam int TAIL_CYCLES   = 40;
   localparam int RANDOM_ITEMS  = 230;
   localparam int CALM_AFTER    = 190;
   localparam int SUM_CAP       = 1048575;

   typedef struct packed {
      logic [SIZE_W-1:0]           desired_width;
      logic [SIZE_W-1:0]           desired_height;
      logic signed [FLEX_IN_W-1:0] flex_weight;
      logic                        last_child;
   } child_req_type;

   typedef struct packed {
      logic [SIZE_W-1:0]       main_size;
      logic signed [POS_W-1:0] cross_pos;
      logic [SIZE_W-1:0]       cross_size;
      logic [SUM_W-1:0]        content_size;
      logic                    overflowed;
      logic                    last_result;
   } placement_type;

   typedef struct packed {
      logic                     axis_vertical;
      logic [SIZE_W-1:0]        gap;
      logic signed [RECT_W-1:0] rect_x;
      logic signed [RECT_W-1:0] rect_y;
      logic signed [RECT_W-1:0] rect_width;
      logic signed [RECT_W-1:0] rect_height;
      logic [1:0]               cross_align;
   } layout_cfg_type;

   typedef struct packed {
      int            cfg_sel;
      int            repeats;
      child_req_type child;
      bit            typed;
      placement_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lfl_req_if req_chan();
   lfl_rsp_if rsp_chan();

   linear_flex_layout DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow of the block: configuration and the container being filled.
   layout_cfg_type    cfg = '0;
   logic [SIZE_W-1:0] main_kept  [DEFAULT_MAX_CHILDREN];
   logic [SIZE_W-1:0] cross_kept [DEFAULT_MAX_CHILDREN];
   int                flex_kept  [DEFAULT_MAX_CHILDREN];
   int                kept_count = 0;
   int                fixed_sum  = 0;
   int                flex_total = 0;
   bit                dropped    = 1'b0;

   placement_type layout_due[$];
   int            mismatch_count = 0;
   bit            calm = 1'b0;

   // Directed configurations: extreme rectangles, end, center and stretch alignment, both axes.
   layout_cfg_type probe_cfg [4] = '{
      '{AXIS_ROW,    32767,  32767, -32768, 32767, -32768, ALIGN_END},
      '{AXIS_COLUMN, 0,      32767,  0,     32767,  32767, ALIGN_CENTER},
      '{AXIS_ROW,    100,   -5,      10,    1000,   50,    ALIGN_STRETCH},
      '{AXIS_COLUMN, 5,     -32768,  32767, -100,   500,   ALIGN_CENTER}
   };

   // The first three rows run with the reset configuration, so their single
   // results can be written down directly.
   script_row_type script [13] = '{
      '{-1, 1,  '{32767, 32767, 0, 1},    1, '{32767, 0, 32767, 32767, 0, 1}},
      '{-1, 1,  '{0, 0, 127, 1},          1, '{0, 0, 0, 0, 0, 1}},
      '{-1, 1,  '{5, 7, -128, 1},         1, '{5, 0, 7, 5, 0, 1}},
      '{0,  15, '{32767, 32767, 0, 0},    0, '0},
      '{-1, 1,  '{32767, 0, 127, 0},      0, '0},
      '{-1, 1,  '{1, 1, 1, 1},            0, '0},
      '{1,  1,  '{100, 200, 1, 0},        0, '0},
      '{-1, 1,  '{32767, 0, 2, 0},        0, '0},
      '{-1, 1,  '{5, 5, 0, 1},            0, '0},
      '{2,  1,  '{10, 20, 3, 0},          0, '0},
      '{-1, 1,  '{0, 0, -1, 0},           0, '0},
      '{-1, 1,  '{7, 7, 127, 0},          0, '0},
      '{3,  1,  '{1, 2, 0, 1},            0, '0}
   };

   function automatic int clip_sum(input int v);
      return (v > SUM_CAP) ? SUM_CAP : v;
   endfunction

   // Stores one child and, on the last one, lays out the whole container.
   task automatic lay_out_child(input child_req_type c);
      int flex, main_len, rect_main, rect_cross, rect_pos, content, avail;
      int space, free_len, used_flex, used_len, next_len, size_main, size_cross, pos;
      placement_type p;
      flex = (c.flex_weight < 0) ? 0 : int'(c.flex_weight);
      if (kept_count < DEFAULT_MAX_CHILDREN) begin
         main_len = cfg.axis_vertical ? c.desired_height : c.desired_width;
         if (kept_count > 0)
            fixed_sum = clip_sum(fixed_sum + cfg.gap);
         if (flex == 0)
            fixed_sum = clip_sum(fixed_sum + main_len);
         flex_total += flex;
         main_kept[kept_count]  = SIZE_W'(main_len);
         cross_kept[kept_count] = cfg.axis_vertical ? c.desired_width : c.desired_height;
         flex_kept[kept_count]  = flex;
         kept_count++;
      end else begin
         dropped = 1'b1;
      end
      if (!c.last_child)
         return;

      rect_main  = cfg.axis_vertical ? cfg.rect_height : cfg.rect_width;
      rect_cross = cfg.axis_vertical ? cfg.rect_width : cfg.rect_height;
      rect_pos   = cfg.axis_vertical ? cfg.rect_x : cfg.rect_y;
      content    = fixed_sum;
      space      = 0;
      if (flex_total > 0) begin
         free_len = rect_main - fixed_sum;
         space    = (free_len > 0) ? free_len : 0;
         content  = clip_sum(content + space);
      end
      avail     = (rect_cross > 0) ? rect_cross : 0;
      used_flex = 0;
      used_len  = 0;

      for (int k = 0; k < kept_count; k++) begin
         size_main = main_kept[k];
         if (flex_total > 0 && flex_kept[k] > 0) begin
            // Cumulative share keeps the flex sizes summing to the free space.
            used_flex += flex_kept[k];
            next_len  = space * used_flex / flex_total;
            size_main = next_len - used_len;
            used_len  = next_len;
         end
         pos        = rect_pos;
         size_cross = cross_kept[k];
         case (cfg.cross_align)
            ALIGN_CENTER: begin
               if (avail > size_cross)
                  pos += (avail - size_cross) / 2;
            end
            ALIGN_END:     pos = rect_pos + rect_cross - size_cross;
            ALIGN_STRETCH: size_cross = avail;
            default: ;
         endcase
         if (pos < -65536)
            pos = -65536;
         if (pos > 65535)
            pos = 65535;
         p.main_size    = size_main[SIZE_W-1:0];
         p.cross_pos    = pos[POS_W-1:0];
         p.cross_size   = size_cross[SIZE_W-1:0];
         p.content_size = content[SUM_W-1:0];
         p.overflowed   = dropped;
         p.last_result  = (k == kept_count - 1);
         layout_due.push_back(p);
      end

      kept_count = 0;
      fixed_sum  = 0;
      flex_total = 0;
      dropped    = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input longint got_v,
                                  input longint want_v);
      $display("%0t: %s got %0d expected %0d", $realtime, what, got_v, want_v);
      mismatch_count++;
   endtask

   task automatic send_child(input child_req_type c);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.desired_width  <= c.desired_width;
      req_chan.desired_height <= c.desired_height;
      req_chan.flex_weight    <= c.flex_weight;
      req_chan.last_child     <= c.last_child;
      do @(posedge clock); while (!req_chan.ready);
      lay_out_child(c);
   endtask

   // Registers change only once the block has drained and gone quiet.
   task automatic reconfigure(input layout_cfg_type c);
      logic [CSR_IDX_W-1:0]  idx  [8];
      logic [CSR_DATA_W-1:0] data [8];
      idx  = '{REG_AXIS, REG_GAP, REG_RECT_X, REG_RECT_Y, REG_RECT_W, REG_RECT_H,
               REG_ALIGN, REG_SPARE};
      data = '{{15'd0, c.axis_vertical}, {1'b0, c.gap}, c.rect_x, c.rect_y,
               c.rect_width, c.rect_height, {14'd0, c.cross_align}, 16'($urandom)};
      req_chan.valid <= 1'b0;
      while (layout_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg = c;
   endtask

   function automatic logic [SIZE_W-1:0] random_length();
      case ($urandom_range(0, 3))
         0:       return SIZE_W'($urandom_range(0, 63));
         1:       return SIZE_W'($urandom);
         2:       return SIZE_W'($urandom_range(0, 2000));
         default: return $urandom_range(0, 1) ? 15'd32767 : 15'd0;
      endcase
   endfunction

   function automatic child_req_type random_child(input logic last);
      child_req_type c;
      c.desired_width  = random_length();
      c.desired_height = random_length();
      case ($urandom_range(0, 4))
         0, 1:    c.flex_weight = 0;
         2:       c.flex_weight = FLEX_IN_W'($urandom_range(1, 8));
         3:       c.flex_weight = FLEX_IN_W'($urandom);
         default: c.flex_weight = FLEX_IN_W'($urandom_range(100, FLEX_MAX));
      endcase
      c.last_child = last;
      return c;
   endfunction

   function automatic logic signed [RECT_W-1:0] random_extent();
      case ($urandom_range(0, 5))
         0:       return RECT_W'($urandom);
         1:       return 16'sd32767;
         2:       return RECT_W'($urandom_range(0, 200));
         default: return RECT_W'($urandom_range(0, 20000));
      endcase
   endfunction

   function automatic logic signed [RECT_W-1:0] random_origin();
      case ($urandom_range(0, 3))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         default: return RECT_W'($urandom);
      endcase
   endfunction

   function automatic layout_cfg_type random_cfg();
      layout_cfg_type c;
      c.axis_vertical = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0:       c.gap = 0;
         1:       c.gap = 15'd32767;
         2:       c.gap = SIZE_W'($urandom);
         default: c.gap = SIZE_W'($urandom_range(0, 20));
      endcase
      c.rect_x      = random_origin();
      c.rect_y      = random_origin();
      c.rect_width  = random_extent();
      c.rect_height = random_extent();
      c.cross_align = 2'($urandom_range(0, 3));
      return c;
   endfunction

   always @(posedge clock) begin : watch
      placement_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.main_size    = rsp_chan.main_size;
         got.cross_pos    = rsp_chan.cross_pos;
         got.cross_size   = rsp_chan.cross_size;
         got.content_size = rsp_chan.content_size;
         got.overflowed   = rsp_chan.overflowed;
         got.last_result  = rsp_chan.last_result;
         if (layout_due.size() == 0) begin
            report_mismatch("unexpected result, main_size", got.main_size, 0);
         end else begin
            want = layout_due.pop_front();
            if (got.main_size !== want.main_size)
               report_mismatch("main_size", got.main_size, want.main_size);
            if (got.cross_pos !== want.cross_pos)
               report_mismatch("cross_pos", got.cross_pos, want.cross_pos);
            if (got.cross_size !== want.cross_size)
               report_mismatch("cross_size", got.cross_size, want.cross_size);
            if (got.content_size !== want.content_size)
               report_mismatch("content_size", got.content_size, want.content_size);
            if (got.overflowed !== want.overflowed)
               report_mismatch("overflowed", got.overflowed, want.overflowed);
            if (got.last_result !== want.last_result)
               report_mismatch("last_result", got.last_result, want.last_result);
         end
      end
   end

   // Result side stalls in bursts, and never once the run turns calm.
   initial begin
      rsp_chan.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (calm || $urandom_range(0, 3) != 0) begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      int sent, left_in_group, phase_left;
      req_chan.valid          = 1'b0;
      req_chan.desired_width  = '0;
      req_chan.desired_height = '0;
      req_chan.flex_weight    = '0;
      req_chan.last_child     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[r]) begin
         if (script[r].cfg_sel >= 0)
            reconfigure(probe_cfg[script[r].cfg_sel]);
         repeat (script[r].repeats) send_child(script[r].child);
         if (script[r].typed) begin
            void'(layout_due.pop_back());
            layout_due.push_back(script[r].want);
         end
      end

      // Phases may end in the middle of a container, so the split of the
      // children already stored must survive a change of axis.
      sent          = 0;
      left_in_group = 0;
      while (sent < RANDOM_ITEMS || left_in_group != 0) begin
         reconfigure(random_cfg());
         phase_left = $urandom_range(8, 40);
         while (phase_left > 0 && (sent < RANDOM_ITEMS || left_in_group != 0)) begin
            if (left_in_group == 0)
               left_in_group = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                           : $urandom_range(1, 6);
            calm = (sent >= CALM_AFTER);
            send_child(random_child(left_in_group == 1));
            left_in_group--;
            sent++;
            phase_left--;
         end
      end

      req_chan.valid <= 1'b0;
      while (layout_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && layout_due.size() == 0) begin
         $display("linear_flex_layout test passed");
      end else begin
         $display("linear_flex_layout test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("linear_flex_layout test failed");
      $finish;
   end

endmodule
